### rtl/i2cm_pkg.sv
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types and constants for the I2C master byte engine.
// ----------------------------------------------------------------------------
package i2cm_pkg;

    localparam int TIMER_W = 16;
    localparam int CFG_W   = 16;

    localparam logic [TIMER_W-1:0] HALF_PERIOD_RST   = TIMER_W'(50);
    localparam logic [TIMER_W-1:0] STRETCH_LIMIT_RST = TIMER_W'(2000);

    // Configuration register indexes
    localparam logic CFG_HALF_PERIOD   = 1'b0;
    localparam logic CFG_STRETCH_LIMIT = 1'b1;

    // Request codes
    typedef enum logic [2:0] {
        REQ_TICK  = 3'd0,
        REQ_START = 3'd1,
        REQ_STOP  = 3'd2,
        REQ_WRITE = 3'd3,
        REQ_READ  = 3'd4
    } req_t;

    // Engine phases
    typedef enum logic [3:0] {
        PH_IDLE = 4'd0,
        PH_S1   = 4'd1,
        PH_S2   = 4'd2,
        PH_P1   = 4'd3,
        PH_PW   = 4'd4,
        PH_P2   = 4'd5,
        PH_P3   = 4'd6,
        PH_W1   = 4'd7,
        PH_WW   = 4'd8,
        PH_W2   = 4'd9,
        PH_R1   = 4'd10,
        PH_RW   = 4'd11,
        PH_R2   = 4'd12
    } phase_t;

    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

endpackage

### rtl/i2c_master_byte_engine.sv
// ----------------------------------------------------------------------------
// i2c_master_byte_engine: open-drain I2C master, one time-base tick per transfer
// Result: registered, shown in the cycle after its tick is accepted.
// Throughput: one tick per cycle while the result drains; state update and result register form one pass.
// Reset: synchronous active-low aresetn; idle, line state released, config to defaults; payload not reset.
// ----------------------------------------------------------------------------
module i2c_master_byte_engine (
    input  logic                         aclk,
    input  logic                         aresetn,
    // configuration write port
    input  logic                         cfg_wr_en,
    input  logic                         cfg_addr,
    input  logic [i2cm_pkg::CFG_W-1:0]   cfg_wdata,
    // tick / command input
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [2:0]                   s_req_type,
    input  logic [7:0]                   s_tx_byte,
    input  logic                         s_master_ack,
    input  logic                         s_scl_level,
    input  logic                         s_sda_level,
    // result output
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_scl_drive_low,
    output logic                         m_sda_drive_low,
    output logic                         m_busy_res,
    output logic                         m_done_res,
    output logic                         m_ack_received,
    output logic [7:0]                   m_rx_byte,
    output logic                         m_stretch_timeout
);

    import i2cm_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [TIMER_W-1:0] half_period_reg;
    logic [TIMER_W-1:0] stretch_limit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_period_reg   <= HALF_PERIOD_RST;
            stretch_limit_reg <= STRETCH_LIMIT_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_HALF_PERIOD:   half_period_reg   <= TIMER_W'(cfg_wdata);
                CFG_STRETCH_LIMIT: stretch_limit_reg <= TIMER_W'(cfg_wdata);
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Engine state
    // ------------------------------------------------------------------
    phase_t             phase_reg,         phase_next;
    logic [3:0]         bit_count_reg,     bit_count_next;
    logic [TIMER_W-1:0] half_timer_reg,    half_timer_next;
    logic [TIMER_W-1:0] stretch_timer_reg, stretch_timer_next;
    logic [7:0]         shift_reg,         shift_next;
    logic               scl_low_reg,       scl_low_next;
    logic               sda_low_reg,       sda_low_next;
    logic               ack_flag_reg,      ack_flag_next;
    logic               timeout_flag_reg,  timeout_flag_next;
    logic               mack_reg,          mack_next;
    logic [7:0]         rx_reg,            rx_next;
    logic               done;

    // Output register
    logic               m_valid_reg;
    logic               out_scl_reg, out_sda_reg, out_busy_reg, out_done_reg;
    logic               out_ack_reg, out_to_reg;
    logic [7:0]         out_rx_reg;

    logic               accept;

    // Accept a tick whenever the result register is free or being drained.
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    // ------------------------------------------------------------------
    // Shared helpers: half-period delay and clock-stretch wait
    // ------------------------------------------------------------------
    logic [TIMER_W:0]   half_inc;
    logic               delay_over;
    logic               stretch_over;
    logic               wait_end;
    logic [3:0]         bit_inc;
    req_t               req;

    assign half_inc     = {1'b0, half_timer_reg} + {{TIMER_W{1'b0}}, 1'b1};
    assign delay_over   = (half_inc >= {1'b0, half_period_reg});
    // the tick that sees SCL still low once the limit is reached times out
    assign stretch_over = !s_scl_level && (stretch_timer_reg >= stretch_limit_reg);
    assign wait_end     = s_scl_level || stretch_over;
    assign bit_inc      = bit_count_reg + 4'd1;
    assign req          = req_t'(s_req_type);

    always_comb begin
        phase_next         = phase_reg;
        bit_count_next     = bit_count_reg;
        half_timer_next    = half_timer_reg;
        stretch_timer_next = stretch_timer_reg;
        shift_next         = shift_reg;
        scl_low_next       = scl_low_reg;
        sda_low_next       = sda_low_reg;
        ack_flag_next      = ack_flag_reg;
        timeout_flag_next  = timeout_flag_reg;
        mack_next          = mack_reg;
        rx_next            = rx_reg;
        done               = 1'b0;

        // delay phases: advance the half timer, wrap on expiry
        if (phase_reg == PH_S1 || phase_reg == PH_S2 || phase_reg == PH_P1 ||
            phase_reg == PH_P2 || phase_reg == PH_P3 || phase_reg == PH_W1 ||
            phase_reg == PH_W2 || phase_reg == PH_R1 || phase_reg == PH_R2) begin
            half_timer_next = delay_over ? '0 : half_inc[TIMER_W-1:0];
        end
        // wait phases: count low ticks, clear when the wait ends
        if (phase_reg == PH_PW || phase_reg == PH_WW || phase_reg == PH_RW) begin
            stretch_timer_next = wait_end ? '0 : stretch_timer_reg + TIMER_W'(1);
        end

        case (phase_reg)
            PH_IDLE: begin
                if (req == REQ_START || req == REQ_STOP ||
                    req == REQ_WRITE || req == REQ_READ) begin
                    ack_flag_next      = 1'b0;
                    timeout_flag_next  = 1'b0;
                    half_timer_next    = '0;
                    stretch_timer_next = '0;
                end
                case (req)
                    REQ_START: begin
                        sda_low_next = 1'b0;
                        scl_low_next = 1'b0;
                        phase_next   = PH_S1;
                    end
                    REQ_STOP: begin
                        sda_low_next = 1'b1;
                        phase_next   = PH_P1;
                    end
                    REQ_WRITE: begin
                        shift_next     = s_tx_byte;
                        bit_count_next = '0;
                        sda_low_next   = !s_tx_byte[7];
                        phase_next     = PH_W1;
                    end
                    REQ_READ: begin
                        shift_next     = '0;
                        bit_count_next = '0;
                        mack_next      = s_master_ack;
                        sda_low_next   = 1'b0;
                        phase_next     = PH_R1;
                    end
                    default: ;
                endcase
            end
            PH_S1: begin
                if (delay_over) begin
                    sda_low_next = 1'b1;
                    phase_next   = PH_S2;
                end
            end
            PH_S2: begin
                if (delay_over) begin
                    scl_low_next = 1'b1;
                    done         = 1'b1;
                end
            end
            PH_P1: begin
                if (delay_over) begin
                    scl_low_next = 1'b0;
                    phase_next   = PH_PW;
                end
            end
            PH_PW: begin
                if (wait_end) begin
                    if (stretch_over) timeout_flag_next = 1'b1;
                    half_timer_next = '0;
                    phase_next      = PH_P2;
                end
            end
            PH_P2: begin
                if (delay_over) begin
                    sda_low_next = 1'b0;
                    phase_next   = PH_P3;
                end
            end
            PH_P3: begin
                if (delay_over) done = 1'b1;
            end
            PH_W1: begin
                if (delay_over) begin
                    scl_low_next = 1'b0;
                    phase_next   = PH_WW;
                end
            end
            PH_WW: begin
                if (stretch_over) begin
                    timeout_flag_next = 1'b1;
                    ack_flag_next     = 1'b0;
                    done              = 1'b1;
                end else if (s_scl_level) begin
                    if (bit_count_reg >= BITS_PER_BYTE) ack_flag_next = !s_sda_level;
                    half_timer_next = '0;
                    phase_next      = PH_W2;
                end
            end
            PH_W2: begin
                if (delay_over) begin
                    scl_low_next   = 1'b1;
                    bit_count_next = bit_inc;
                    if (bit_inc < BITS_PER_BYTE) begin
                        sda_low_next = !shift_reg[~bit_inc[2:0]];
                        phase_next   = PH_W1;
                    end else if (bit_inc == BITS_PER_BYTE) begin
                        sda_low_next = 1'b0;    // release SDA for the slave ACK
                        phase_next   = PH_W1;
                    end else begin
                        done = 1'b1;
                    end
                end
            end
            PH_R1: begin
                if (delay_over) begin
                    scl_low_next = 1'b0;
                    phase_next   = PH_RW;
                end
            end
            PH_RW: begin
                if (wait_end) begin
                    if (stretch_over) timeout_flag_next = 1'b1;
                    if (bit_count_reg < BITS_PER_BYTE) shift_next = {shift_reg[6:0], s_sda_level};
                    half_timer_next = '0;
                    phase_next      = PH_R2;
                end
            end
            PH_R2: begin
                if (delay_over) begin
                    scl_low_next   = 1'b1;
                    bit_count_next = bit_inc;
                    if (bit_inc < BITS_PER_BYTE) begin
                        phase_next = PH_R1;
                    end else if (bit_inc == BITS_PER_BYTE) begin
                        sda_low_next = mack_reg;    // drive master ACK/NACK
                        phase_next   = PH_R1;
                    end else begin
                        sda_low_next = 1'b0;
                        rx_next      = shift_reg;
                        done         = 1'b1;
                    end
                end
            end
            default: begin
                done = 1'b1;
            end
        endcase

        // a finished command drops back to idle with the timers cleared
        if (done) begin
            phase_next         = PH_IDLE;
            half_timer_next    = '0;
            stretch_timer_next = '0;
        end
    end

    // ------------------------------------------------------------------
    // State and result registers: advance only on an accepted transfer
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg         <= PH_IDLE;
            bit_count_reg     <= '0;
            half_timer_reg    <= '0;
            stretch_timer_reg <= '0;
            shift_reg         <= '0;
            scl_low_reg       <= 1'b0;
            sda_low_reg       <= 1'b0;
            ack_flag_reg      <= 1'b0;
            timeout_flag_reg  <= 1'b0;
            mack_reg          <= 1'b0;
            rx_reg            <= '0;
        end else if (accept) begin
            phase_reg         <= phase_next;
            bit_count_reg     <= bit_count_next;
            half_timer_reg    <= half_timer_next;
            stretch_timer_reg <= stretch_timer_next;
            shift_reg         <= shift_next;
            scl_low_reg       <= scl_low_next;
            sda_low_reg       <= sda_low_next;
            ack_flag_reg      <= ack_flag_next;
            timeout_flag_reg  <= timeout_flag_next;
            mack_reg          <= mack_next;
            rx_reg            <= rx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // result payload: load with the post-tick values, hold while stalled
    always_ff @(posedge aclk) begin
        if (accept) begin
            out_scl_reg  <= scl_low_next;
            out_sda_reg  <= sda_low_next;
            out_busy_reg <= (phase_next != PH_IDLE);
            out_done_reg <= done;
            out_ack_reg  <= ack_flag_next;
            out_rx_reg   <= rx_next;
            out_to_reg   <= timeout_flag_next;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_scl_drive_low   = out_scl_reg;
    assign m_sda_drive_low   = out_sda_reg;
    assign m_busy_res        = out_busy_reg;
    assign m_done_res        = out_done_reg;
    assign m_ack_received    = out_ack_reg;
    assign m_rx_byte         = out_rx_reg;
    assign m_stretch_timeout = out_to_reg;

endmodule

### rtl/i2cm_checker.sv
// ----------------------------------------------------------------------------
// i2cm_checker
// Port-level checks for the I2C master byte engine, bound to the top level.
// ----------------------------------------------------------------------------
module i2cm_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_ready,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic                         m_busy_res,
    input logic                         m_done_res,
    input logic                         m_ack_received,
    input logic [7:0]                   m_rx_byte,
    input logic                         m_stretch_timeout
);

    // a stalled result holds its payload
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_rx_byte) && $stable(m_done_res))
        else $error("result changed while stalled");

    // the engine never stalls the tick stream when results drain
    a_ready_follow: assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |-> s_ready)
        else $error("input stalled although output drains");

    // a finishing command leaves the engine idle
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_done_res |-> !m_busy_res)
        else $error("done reported while busy");

    // a stretch timeout always clears the write ACK
    a_ack_to: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ack_received |-> !m_stretch_timeout)
        else $error("ACK and timeout reported together");

endmodule

bind i2c_master_byte_engine i2cm_checker u_i2cm_checker (.*);
